@@ rtl/sitoa_pkg.sv @@
// Shared types and constants for the signed integer to decimal ASCII unit.
// No dependencies; every other file of the block imports this package.
package sitoa_pkg;

  localparam int ValueWidth    = 32;
  localparam int CharWidth     = 8;
  localparam int NumDigits     = 10;
  localparam int DigitWidth    = 4;
  localparam int BcdWidth      = NumDigits * DigitWidth;
  localparam int DigitIdxWidth = $clog2(NumDigits);
  localparam int ShiftCntWidth = $clog2(ValueWidth);

  localparam logic [CharWidth-1:0]     AsciiZero  = 8'd48;
  localparam logic [CharWidth-1:0]     AsciiMinus = 8'd45;
  localparam logic [ShiftCntWidth-1:0] LastShift  = ShiftCntWidth'(ValueWidth - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIND,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture sign and magnitude
    logic shift;       // one double-dabble step
    logic find;        // locate most significant nonzero digit
    logic emit_sign;   // load '-' into output register
    logic emit_digit;  // load current digit, step pointer down
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic neg;
    logic last_shift;
    logic ptr_zero;
  } status_t;

endpackage

@@ rtl/sitoa_in_if.sv @@
// Input channel: one signed 32-bit value per transaction.
// Depends on sitoa_pkg.
interface sitoa_in_if
  import sitoa_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic signed [ValueWidth-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

@@ rtl/sitoa_out_if.sv @@
// Output channel: one ASCII character and its end-of-number flag per transaction.
// Depends on sitoa_pkg.
interface sitoa_out_if
  import sitoa_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] char_code;
  logic                 last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

@@ rtl/signed_int_to_decimal_ascii_unit.sv @@
// Top level of the signed integer to decimal ASCII unit.
// Depends on sitoa_pkg, sitoa_in_if, sitoa_out_if, sitoa_ctrl and sitoa_datapath.
//
// Converts one signed 32-bit two's complement value per input transaction
// into its decimal text, sent as one ASCII character per output transaction,
// most significant digit first. Negative values are preceded by '-', zero
// gives a single '0', leading zeros are never sent, and last is high on the
// final character of each number. The most negative value comes out exactly
// as "-2147483648". Sequence: the value is accepted, then a shift-add-3
// binary-to-BCD loop runs one bit per cycle through the magnitude, the
// leading digit is located, and the characters leave the output register
// at one per cycle while the sink is ready. Each number has 1 to 11
// characters. One number is converted at a time; the next value is taken
// once the final character of the current one has been loaded into the
// output register, while that character still waits.
module signed_int_to_decimal_ascii_unit
  import sitoa_pkg::*;
(
  input logic         clk,
  input logic         rst,
  sitoa_in_if.sink    din,
  sitoa_out_if.source dout
);

  cmd_t    cmd;
  status_t status;

  sitoa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (din.valid),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sitoa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (din.value),
    .status    (status),
    .char_code (dout.char_code),
    .last      (dout.last)
  );

`ifndef SYNTHESIS
  // one number at a time: no new value right after one is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready) |=> !din.ready)
    else $error("input taken while a conversion is running");

  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

  // the sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.char_code == AsciiMinus) |-> !dout.last)
    else $error("minus sign flagged as last character");

  // a new character is loaded only when the previous one is gone or leaving
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_sign || cmd.emit_digit) |-> (!dout.valid || dout.ready))
    else $error("pending character overwritten");
`endif

endmodule

@@ rtl/sitoa_datapath.sv @@
// Datapath: magnitude capture, shift-add-3 BCD conversion, digit pointer
// and the output character register. Depends on sitoa_pkg.
module sitoa_datapath
  import sitoa_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  input  logic signed [ValueWidth-1:0] value,
  output status_t                      status,
  output logic [CharWidth-1:0]         char_code,
  output logic                         last
);

  logic                     neg;
  logic [ValueWidth-1:0]    bin;
  logic [BcdWidth-1:0]      bcd;
  logic [BcdWidth-1:0]      bcd_adj;
  logic [DigitIdxWidth-1:0] ptr;
  logic [DigitIdxWidth-1:0] msd;
  logic [ShiftCntWidth-1:0] cnt;
  logic [DigitWidth-1:0]    cur_digit;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    logic [DigitWidth-1:0] d;
    d       = '0;
    bcd_adj = bcd;
    for (int i = 0; i < NumDigits; i++) begin
      d = bcd[i*DigitWidth +: DigitWidth];
      bcd_adj[i*DigitWidth +: DigitWidth] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  // highest nonzero digit; zero when the whole number is zero
  always_comb begin
    msd = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[i*DigitWidth +: DigitWidth] != '0) begin
        msd = DigitIdxWidth'(i);
      end
    end
  end

  assign cur_digit = bcd[ptr*DigitWidth +: DigitWidth];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ptr <= '0;
    end else begin
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.shift) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.find) begin
        ptr <= msd;
      end else if (cmd.emit_digit && ptr != '0) begin
        ptr <= ptr - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= value[ValueWidth-1];
      // unsigned 32-bit magnitude; the most negative value maps to 2^31 exactly
      bin <= value[ValueWidth-1] ? (~value) + 1'b1 : value;
      bcd <= '0;
    end else if (cmd.shift) begin
      bcd <= {bcd_adj[BcdWidth-2:0], bin[ValueWidth-1]};
      bin <= {bin[ValueWidth-2:0], 1'b0};
    end
    if (cmd.emit_sign) begin
      char_code <= AsciiMinus;
      last      <= 1'b0;
    end else if (cmd.emit_digit) begin
      char_code <= AsciiZero + {{(CharWidth-DigitWidth){1'b0}}, cur_digit};
      last      <= (ptr == '0);
    end
  end

  assign status.neg        = neg;
  assign status.last_shift = (cnt == LastShift);
  assign status.ptr_zero   = (ptr == '0);

endmodule

@@ rtl/sitoa_ctrl.sv @@
// Controller state machine: input handshake, conversion sequencing and the
// output valid flag. Depends on sitoa_pkg.
module sitoa_ctrl
  import sitoa_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  // output register can take a new character this cycle
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_CONV;
      ST_CONV:  if (status.last_shift) state_next = ST_FIND;
      ST_FIND:  state_next = status.neg ? ST_SIGN : ST_DIGIT;
      ST_SIGN:  if (out_free) state_next = ST_DIGIT;
      ST_DIGIT: if (out_free && status.ptr_zero) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV:  cmd.shift      = 1'b1;
      ST_FIND:  cmd.find       = 1'b1;
      ST_SIGN:  cmd.emit_sign  = out_free;
      ST_DIGIT: cmd.emit_digit = out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit_sign || cmd.emit_digit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
